// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/nfca_pkg.sv =====
// Types and constants of the next-fit chunk allocator.
package nfca_pkg;

    localparam int LEN_W   = 19;
    localparam int ADDR_W  = 18;
    localparam int CFG_W   = 13;
    localparam int ST_W    = 2;
    localparam int PA_W    = 3;
    localparam int PDATA_W = 32;

    localparam logic [CFG_W-1:0] CB_RESET = 13'd128;
    localparam logic [LEN_W-1:0] LEN_MAX  = 19'h7FFFF;

    localparam logic [0:0] REG_CHUNK_BYTES = 1'b0;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [ST_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [ST_W-1:0] STATUS_NO_SPACE = 2'd1;
    localparam logic [ST_W-1:0] STATUS_BAD_ADDR = 2'd2;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_RD,
        ST_EVAL,
        ST_SKIP,
        ST_FA_WAIT,
        ST_F_RD,
        ST_FB_WAIT,
        ST_DONE
    } fsm_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

// ===== rtl/nfca_if.sv =====
// Request and result channel interfaces of the allocator.
interface nfca_req_if;
    import nfca_pkg::*;

    logic              valid;
    logic              ready;
    logic              op;
    logic [LEN_W-1:0]  size_bytes;
    logic [ADDR_W-1:0] address;

    modport source (output valid, output op, output size_bytes, output address, input ready);
    modport sink (input valid, input op, input size_bytes, input address, output ready);
endinterface

interface nfca_rsp_if;
    import nfca_pkg::*;

    logic              valid;
    logic              ready;
    logic [ST_W-1:0]   status;
    logic [ADDR_W-1:0] granted_address;
    logic [LEN_W-1:0]  bytes_in_use;

    modport source (output valid, output status, output granted_address,
                    output bytes_in_use, input ready);
    modport sink (input valid, input status, input granted_address,
                  input bytes_in_use, output ready);
endinterface

// ===== rtl/nfca_div.sv =====
// Restoring divider, one quotient bit per cycle.
`include "assert_macros.svh"

module nfca_div #(
    parameter int DIVISOR_W = 13
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [nfca_pkg::LEN_W-1:0]   dividend,
    input  logic [DIVISOR_W-1:0]         divisor,
    output nfca_pkg::div_status_t        status,
    output logic [nfca_pkg::LEN_W-1:0]   quotient,
    output logic [DIVISOR_W-1:0]         remainder
);
    import nfca_pkg::*;

    localparam int CNT_W = $clog2(LEN_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(LEN_W - 1);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [LEN_W-1:0]     quo_reg, quo_next;
    logic [DIVISOR_W-1:0] rem_reg, rem_next;
    logic [DIVISOR_W-1:0] dvs_reg, dvs_next;
    logic [DIVISOR_W:0]   trial;
    logic                 ge;

    assign trial = {rem_reg, quo_reg[LEN_W-1]};
    assign ge    = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            // shift in the next dividend bit, subtract when it fits
            quo_next = {quo_reg[LEN_W-2:0], ge};
            rem_next = ge ? DIVISOR_W'(trial - {1'b0, dvs_reg}) : DIVISOR_W'(trial);
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quo_reg;
    assign remainder   = rem_reg;

    `ASSERT_IMPL(a_rem_below_divisor, done_reg && dvs_reg != '0, rem_reg < dvs_reg, "remainder not below divisor")
    `ASSERT_IMPL(a_no_restart, start, !busy_reg, "divider restarted while busy")
    `ASSERT_NEXT(a_done_pulse, done_reg, !done_reg && !busy_reg, "done held longer than one cycle")

endmodule

// ===== rtl/next_fit_chunk_allocator.sv =====
// Top level of the next-fit chunk allocator: descriptor memory, scan and free control.
// Allocate: a next-fit scan of the descriptors from the cursor, where a walk over an
//   allocation advances one chunk per cycle.
// Free: two divider runs (address to chunk index, length to rounded bytes). One request
//   is in flight at a time; the next is taken once its result sits in the output register.
//   After reset a sweep zeroes the memory.
`include "assert_macros.svh"

module next_fit_chunk_allocator #(
    parameter int NUM_CHUNKS      = 64,
    parameter int MAX_CHUNK_BYTES = 4096
) (
    input  logic                           clk,
    input  logic                           rst_n,
    nfca_req_if.sink                       req,
    nfca_rsp_if.source                     rsp,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [nfca_pkg::PA_W-1:0]      paddr,
    input  logic [nfca_pkg::PDATA_W-1:0]   pwdata,
    output logic [nfca_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready
);
    import nfca_pkg::*;

    localparam int IW    = $clog2(NUM_CHUNKS);
    localparam int CNT_W = $clog2(NUM_CHUNKS + 1);
    localparam int STP_W = CNT_W + 1;
    localparam int CW    = $clog2(MAX_CHUNK_BYTES + 1);
    localparam int TOT_W = $clog2(NUM_CHUNKS * MAX_CHUNK_BYTES + 1);
    localparam int SUM_W = ((TOT_W > LEN_W) ? TOT_W : LEN_W) + 1;
    localparam int PRD_W = IW + CW;
    localparam int BK_W  = LEN_W + 1;
    localparam logic [CNT_W-1:0] N_CNT     = CNT_W'(NUM_CHUNKS);
    localparam logic [IW-1:0]    LAST_IDX  = IW'(NUM_CHUNKS - 1);
    localparam logic [CW-1:0]    MAX_CB    = CW'(MAX_CHUNK_BYTES);
    localparam logic [SUM_W-1:0] LEN_MAX_S = SUM_W'(LEN_MAX);

    function automatic logic [IW-1:0] wrap_pos(input logic [CNT_W-1:0] pos);
        wrap_pos = (pos == N_CNT) ? '0 : IW'(pos);
    endfunction

    // configuration
    logic [CFG_W-1:0] cb_reg;
    logic [CW-1:0]    cb_eff;
    logic [TOT_W-1:0] total_reg;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[PA_W-1:2] == REG_CHUNK_BYTES) ? PDATA_W'(cb_reg) : '0;

    always_comb
    begin
        if (cb_reg == '0)
            cb_eff = CW'(1);
        else if (32'(cb_reg) > 32'(MAX_CHUNK_BYTES))
            cb_eff = MAX_CB;
        else
            cb_eff = CW'(cb_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cb_reg <= CB_RESET;
        else if (cfg_wr && paddr[PA_W-1:2] == REG_CHUNK_BYTES)
            cb_reg <= pwdata[CFG_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        total_reg <= TOT_W'(NUM_CHUNKS) * TOT_W'(cb_eff);
    end

    // descriptor memory: allocated length at the first chunk of each allocation, zero elsewhere
    logic [LEN_W-1:0] len_mem [NUM_CHUNKS];
    logic [LEN_W-1:0] rdata_reg;
    logic             mem_we;
    logic [IW-1:0]    mem_waddr;
    logic [LEN_W-1:0] mem_wdata;
    logic [IW-1:0]    mem_raddr;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            len_mem[mem_waddr] <= mem_wdata;
        rdata_reg <= len_mem[mem_raddr];
    end

    // divider
    logic              div_start;
    logic [LEN_W-1:0]  div_dividend;
    div_status_t       div_st;
    logic [LEN_W-1:0]  div_quo;
    logic [CW-1:0]     div_rem;

    nfca_div #(
        .DIVISOR_W (CW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (cb_eff),
        .status    (div_st),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // control and working registers
    fsm_state_t        state_reg, state_next;
    logic [IW-1:0]     cur_reg, cur_next;
    logic [LEN_W-1:0]  used_reg, used_next;
    logic [IW-1:0]     clr_reg, clr_next;
    logic              out_valid_reg, out_valid_next;

    logic [LEN_W-1:0]  size_reg, size_next;
    logic [CNT_W-1:0]  steps_reg, steps_next;
    logic [CNT_W-1:0]  k_reg, k_next;
    logic [TOT_W-1:0]  runb_reg, runb_next;
    logic [LEN_W-1:0]  skrem_reg, skrem_next;
    logic [IW-1:0]     skpos_reg, skpos_next;
    logic              skgrant_reg, skgrant_next;
    logic [IW-1:0]     gidx_reg, gidx_next;
    logic              gok_reg, gok_next;
    logic [ST_W-1:0]   status_reg, status_next;
    logic [IW-1:0]     fidx_reg, fidx_next;
    logic [LEN_W-1:0]  flen_reg, flen_next;

    logic [ST_W-1:0]   out_status_reg;
    logic [ADDR_W-1:0] out_gaddr_reg;
    logic [LEN_W-1:0]  out_used_reg;
    logic              load_out;
    logic              req_ready;

    // datapath terms
    logic [CNT_W-1:0]  pos_k, nk, end_pos, run_len, cap_pos, skip_step;
    logic [TOT_W-1:0]  nrb;
    logic [SUM_W-1:0]  size_s, used_s, tot_s, avail_s, grant_sum;
    logic              fit, nospace, run_cap;
    logic [STP_W-1:0]  steps_run;
    logic [LEN_W-1:0]  used_grant;
    logic [BK_W-1:0]   back;
    logic [PRD_W-1:0]  gprod;

    assign pos_k      = CNT_W'(cur_reg) + k_reg;
    assign nk         = k_reg + 1'b1;
    assign end_pos    = CNT_W'(cur_reg) + nk;
    assign nrb        = runb_reg + TOT_W'(cb_eff);
    assign size_s     = SUM_W'(size_reg);
    assign used_s     = SUM_W'(used_reg);
    assign tot_s      = SUM_W'(total_reg);
    assign avail_s    = (used_s < tot_s) ? (tot_s - used_s) : '0;
    assign nospace    = size_s > avail_s;
    assign fit        = size_s <= SUM_W'(nrb);
    assign grant_sum  = used_s + SUM_W'(nrb);
    assign used_grant = (grant_sum > LEN_MAX_S) ? LEN_MAX : LEN_W'(grant_sum);
    // a free run ends either at the next allocation or at the pool end
    assign run_len    = (rdata_reg == '0) ? nk : k_reg;
    assign steps_run  = STP_W'(steps_reg) + STP_W'(run_len);
    assign run_cap    = steps_run >= STP_W'(NUM_CHUNKS);
    assign cap_pos    = CNT_W'(cur_reg) + (N_CNT - steps_reg);
    assign skip_step  = CNT_W'(skpos_reg) + 1'b1;
    assign back       = BK_W'(flen_reg) - BK_W'(div_rem)
                        + ((div_rem != '0) ? BK_W'(cb_eff) : '0);
    assign gprod      = PRD_W'(gidx_reg) * PRD_W'(cb_eff);

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        used_next      = used_reg;
        clr_next       = clr_reg;
        size_next      = size_reg;
        steps_next     = steps_reg;
        k_next         = k_reg;
        runb_next      = runb_reg;
        skrem_next     = skrem_reg;
        skpos_next     = skpos_reg;
        skgrant_next   = skgrant_reg;
        gidx_next      = gidx_reg;
        gok_next       = gok_reg;
        status_next    = status_reg;
        fidx_next      = fidx_reg;
        flen_next      = flen_reg;
        mem_we         = 1'b0;
        mem_waddr      = cur_reg;
        mem_wdata      = '0;
        mem_raddr      = cur_reg;
        div_start      = 1'b0;
        div_dividend   = LEN_W'(req.address);
        load_out       = 1'b0;
        req_ready      = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == LAST_IDX)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req.valid)
                begin
                    size_next   = req.size_bytes;
                    gok_next    = 1'b0;
                    status_next = STATUS_OK;
                    if (req.op == OP_ALLOC)
                        state_next = ST_CHECK;
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = ST_FA_WAIT;
                    end
                end
            end
            ST_CHECK:
            begin
                steps_next = '0;
                k_next     = '0;
                runb_next  = '0;
                if (nospace)
                begin
                    status_next = STATUS_NO_SPACE;
                    state_next  = ST_DONE;
                end
                else
                    state_next = ST_EVAL;
            end
            ST_RD:
            begin
                k_next     = '0;
                runb_next  = '0;
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                priority if (k_reg == '0 && size_reg == '0)
                begin
                    // zero size takes the cursor chunk whatever it holds
                    gok_next  = 1'b1;
                    gidx_next = cur_reg;
                    if (rdata_reg == '0)
                    begin
                        cur_next   = wrap_pos(CNT_W'(cur_reg) + 1'b1);
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        skrem_next   = rdata_reg;
                        skpos_next   = cur_reg;
                        skgrant_next = 1'b1;
                        state_next   = ST_SKIP;
                    end
                end
                else if (k_reg == '0 && rdata_reg != '0)
                begin
                    steps_next   = steps_reg + 1'b1;
                    skrem_next   = rdata_reg;
                    skpos_next   = cur_reg;
                    skgrant_next = 1'b0;
                    state_next   = ST_SKIP;
                end
                else if (rdata_reg == '0 && fit)
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = cur_reg;
                    mem_wdata  = size_reg;
                    used_next  = used_grant;
                    cur_next   = wrap_pos(end_pos);
                    gok_next   = 1'b1;
                    gidx_next  = cur_reg;
                    state_next = ST_DONE;
                end
                else if (rdata_reg == '0 && end_pos != N_CNT)
                begin
                    // extend the free run, read the next descriptor
                    k_next    = nk;
                    runb_next = nrb;
                    mem_raddr = IW'(end_pos);
                end
                else
                begin
                    if (run_cap)
                    begin
                        cur_next    = wrap_pos(cap_pos);
                        status_next = STATUS_NO_SPACE;
                        state_next  = ST_DONE;
                    end
                    else
                    begin
                        steps_next = CNT_W'(steps_run);
                        cur_next   = wrap_pos(CNT_W'(cur_reg) + run_len);
                        state_next = ST_RD;
                    end
                end
            end
            ST_SKIP:
            begin
                if (skrem_reg <= LEN_W'(cb_eff) || skip_step == N_CNT)
                begin
                    cur_next = wrap_pos(skip_step);
                    if (skgrant_reg)
                        state_next = ST_DONE;
                    else if (steps_reg == N_CNT)
                    begin
                        status_next = STATUS_NO_SPACE;
                        state_next  = ST_DONE;
                    end
                    else
                        state_next = ST_RD;
                end
                else
                begin
                    skrem_next = skrem_reg - LEN_W'(cb_eff);
                    skpos_next = IW'(skip_step);
                end
            end
            ST_FA_WAIT:
            begin
                mem_raddr = IW'(div_quo);
                if (div_st.done)
                begin
                    if (div_rem != '0 || div_quo >= LEN_W'(NUM_CHUNKS))
                    begin
                        cur_next    = '0;
                        status_next = STATUS_BAD_ADDR;
                        state_next  = ST_DONE;
                    end
                    else
                    begin
                        fidx_next  = IW'(div_quo);
                        state_next = ST_F_RD;
                    end
                end
            end
            ST_F_RD:
            begin
                if (rdata_reg == '0)
                begin
                    cur_next   = fidx_reg;
                    state_next = ST_DONE;
                end
                else
                begin
                    flen_next    = rdata_reg;
                    div_start    = 1'b1;
                    div_dividend = rdata_reg;
                    state_next   = ST_FB_WAIT;
                end
            end
            ST_FB_WAIT:
            begin
                if (div_st.done)
                begin
                    used_next  = (back >= BK_W'(used_reg)) ? '0 : LEN_W'(BK_W'(used_reg) - back);
                    mem_we     = 1'b1;
                    mem_waddr  = fidx_reg;
                    cur_next   = fidx_reg;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (load_out)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cur_reg       <= '0;
            used_reg      <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            used_reg      <= used_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        size_reg    <= size_next;
        steps_reg   <= steps_next;
        k_reg       <= k_next;
        runb_reg    <= runb_next;
        skrem_reg   <= skrem_next;
        skpos_reg   <= skpos_next;
        skgrant_reg <= skgrant_next;
        gidx_reg    <= gidx_next;
        gok_reg     <= gok_next;
        status_reg  <= status_next;
        fidx_reg    <= fidx_next;
        flen_reg    <= flen_next;
        if (load_out)
        begin
            out_status_reg <= status_reg;
            out_gaddr_reg  <= gok_reg ? ADDR_W'(gprod) : '0;
            out_used_reg   <= used_reg;
        end
    end

    assign req.ready           = req_ready;
    assign rsp.valid           = out_valid_reg;
    assign rsp.status          = out_status_reg;
    assign rsp.granted_address = out_gaddr_reg;
    assign rsp.bytes_in_use    = out_used_reg;

    `ASSERT_IMPL(a_eval_in_range, state_reg == ST_EVAL, pos_k < N_CNT, "descriptor read beyond pool end")
    `ASSERT_NEXT(a_nospace_hold, state_reg == ST_CHECK && nospace, $stable(cur_reg) && $stable(used_reg), "state moved on early no space")
    `ASSERT_IMPL(a_grant_write, mem_we && state_reg == ST_EVAL, mem_wdata != '0 && mem_waddr == cur_reg, "bad grant write")
    `ASSERT_NEXT(a_result_out, load_out, rsp.valid && rsp.bytes_in_use == $past(used_reg), "result not presented")
    `ASSERT_IMPL(a_div_idle_start, div_start, !div_st.busy, "divider started while busy")

endmodule
